@@ hdl/nsc_pkg.sv @@
// ---------------------------------------------------------------------------
// nsc_pkg
// Shared types, constants and helpers of the nearest-site catchment block.
// ---------------------------------------------------------------------------
`default_nettype none
package nsc_pkg;

   localparam int MAX_SITES   = 64;
   localparam int SITE_W      = $clog2(MAX_SITES);
   localparam int CNT_W       = SITE_W + 1;
   localparam int GRID_DIM    = 128;
   localparam int FAR_CNT_W   = 15;
   localparam int FAR_CNT_RAW = GRID_DIM * GRID_DIM;
   localparam logic [FAR_CNT_W-1:0] FAR_CNT_MAX =
      (FAR_CNT_RAW > 32767) ? 15'h7fff : FAR_CNT_W'(FAR_CNT_RAW);
   localparam int FAR_RADIUS  = 5;
   localparam logic [32:0] FAR_LIMIT = 33'(FAR_RADIUS * FAR_RADIUS) << 16;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_CELL   = 2'd1,
      OP_FINISH = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [15:0] site_x;
      logic signed [15:0] site_y;
      logic [13:0]        site_capacity;
      logic [6:0]         cell_row;
      logic [6:0]         cell_col;
      logic [15:0]        cell_population;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  nearest_site;
      logic        site_found;
      logic        far_flag;
      logic [31:0] days_needed;
      logic [31:0] total_people;
      logic [31:0] far_people;
      logic [14:0] far_cells;
      logic        table_full;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [13:0]        cap;
   } site_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic        rem_nz;
   } div_res_type;

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hffff_ffff : s[31:0];
   endfunction

endpackage
`default_nettype wire

@@ hdl/nearest_site_catchment.sv @@
// ---------------------------------------------------------------------------
// nearest_site_catchment
// Assigns grid cells to the nearest loaded site and reports the bottleneck.
// ---------------------------------------------------------------------------
//  channel   ports                      transfer
//  request   start, busy, req_data      start high while busy low
//  response  rsp_valid, rsp_data        one-cycle strobe, cannot be held off
//
//  load and clear: answered straight from idle. cell: a scan of the site RAM
//  at one site read per cycle, then the pop RAM read-modify-write; answered
//  straight from idle with an empty table.
//  finish: a read, multiply and compare step per loaded site, then the ceiling
//  divider; answered straight from idle with an empty table.
//  synchronous reset and clear empty the table at once; no sweep is needed.
//  the response strobe never stalls the block.
`default_nettype none
module nearest_site_catchment (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire nsc_pkg::req_type req_data,
   output logic                  rsp_valid,
   output nsc_pkg::rsp_type      rsp_data
);
   import nsc_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_SCAN    = 8'b0000_0010,
      ST_POP_RD  = 8'b0000_0100,
      ST_POP_WR  = 8'b0000_1000,
      ST_FIN_RD  = 8'b0001_0000,
      ST_FIN_MUL = 8'b0010_0000,
      ST_FIN_CMP = 8'b0100_0000,
      ST_DIV     = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [31:0]           total_ff, total_in;
   logic [31:0]           far_sum_ff, far_sum_in;
   logic [FAR_CNT_W-1:0]  far_cnt_ff, far_cnt_in;
   logic [14:0]           px_ff, px_in, py_ff, py_in;
   logic [15:0]           cpop_ff, cpop_in;
   logic [CNT_W-1:0]      iss_ff, iss_in;
   logic                  v1_ff, v1_in, v2_ff, v2_in;
   logic [SITE_W-1:0]     k1_ff, k1_in, k2_ff, k2_in;
   logic [31:0]           sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [SITE_W-1:0]     best_ff, best_in;
   logic [32:0]           best_d_ff, best_d_in;
   logic                  far_ff, far_in;
   logic [CNT_W-1:0]      fk_ff, fk_in;
   logic [45:0]           lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic [31:0]           cand_pop_ff, cand_pop_in, bpop_ff, bpop_in;
   logic [13:0]           cand_cap_ff, cand_cap_in, bcap_ff, bcap_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  site_we, pop_we, div_start;
   logic [SITE_W-1:0]     site_wa, site_ra, pop_wa, pop_ra;
   site_type              site_wd, site_rd;
   logic [31:0]           pop_wd, pop_rd;
   div_res_type           div_res;
   logic                  accept;
   logic [17:0]           dx, dy;
   logic [15:0]           ax, ay;
   logic [32:0]           dist_sum;
   logic [31:0]           new_pop;

   assign accept = start && !busy;

   // site coordinates and capacity
   nsc_ram #(.WIDTH($bits(site_type)), .DEPTH(MAX_SITES)) u_site_ram (
      .clock   (clock),
      .wr_en   (site_we),
      .wr_addr (site_wa),
      .wr_data (site_wd),
      .rd_addr (site_ra),
      .rd_data (site_rd)
   );

   // per-site population sums
   nsc_ram #(.WIDTH(32), .DEPTH(MAX_SITES)) u_pop_ram (
      .clock   (clock),
      .wr_en   (pop_we),
      .wr_addr (pop_wa),
      .wr_data (pop_wd),
      .rd_addr (pop_ra),
      .rd_data (pop_rd)
   );

   // ceiling of bottleneck population over capacity
   nsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (bpop_in),
      .divisor  (bcap_in),
      .res      (div_res)
   );

   // distance terms from the site read out this cycle
   always_comb begin
      dx = 18'({3'b0, px_ff}) - 18'(signed'(site_rd.x));
      dy = 18'({3'b0, py_ff}) - 18'(signed'(site_rd.y));
      ax = dx[17] ? 16'(-dx) : dx[15:0];
      ay = dy[17] ? 16'(-dy) : dy[15:0];
      dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      new_pop  = sat_add32(pop_rd, {16'b0, cpop_ff});
   end

   // control and datapath next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      far_sum_in   = far_sum_ff;
      far_cnt_in   = far_cnt_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      cpop_in      = cpop_ff;
      iss_in       = iss_ff;
      v1_in        = 1'b0;
      k1_in        = iss_ff[SITE_W-1:0];
      v2_in        = v1_ff;
      k2_in        = k1_ff;
      sqx_in       = 32'(ax) * 32'(ax);
      sqy_in       = 32'(ay) * 32'(ay);
      best_in      = best_ff;
      best_d_in    = best_d_ff;
      far_in       = far_ff;
      fk_in        = fk_ff;
      lhs_in       = 46'(pop_rd) * 46'(bcap_ff);
      rhs_in       = 46'(bpop_ff) * 46'(site_rd.cap);
      cand_pop_in  = pop_rd;
      cand_cap_in  = site_rd.cap;
      bpop_in      = bpop_ff;
      bcap_in      = bcap_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      site_we      = 1'b0;
      site_wa      = count_ff[SITE_W-1:0];
      site_wd.x    = req_data.site_x;
      site_wd.y    = req_data.site_y;
      site_wd.cap  = (req_data.site_capacity == '0) ? 14'd1 : req_data.site_capacity;
      pop_we       = 1'b0;
      pop_wa       = count_ff[SITE_W-1:0];
      pop_wd       = '0;
      site_ra      = (state_ff == ST_SCAN) ? iss_ff[SITE_W-1:0] : fk_ff[SITE_W-1:0];
      pop_ra       = (state_ff == ST_POP_RD) ? best_ff : fk_ff[SITE_W-1:0];
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in.kind  = req_data.opcode;
               case (op_type'(req_data.opcode))
                  OP_LOAD: begin
                     if (count_ff >= CNT_W'(MAX_SITES)) begin
                        rsp_in.table_full = 1'b1;
                     end else begin
                        site_we = 1'b1;
                        pop_we  = 1'b1;
                        count_in = count_ff + 1'b1;
                        rsp_in.nearest_site = 6'(count_ff);
                     end
                     rsp_in.site_found = 1'b1;
                     if (count_ff == '0 && count_in == '0) begin
                        rsp_in.site_found = 1'b0;
                     end
                  end
                  OP_CELL: begin
                     px_in   = {req_data.cell_row, 8'b0};
                     py_in   = {req_data.cell_col, 8'b0};
                     cpop_in = req_data.cell_population;
                     if (count_ff == '0) begin
                        total_in   = sat_add32(total_ff, {16'b0, req_data.cell_population});
                        far_sum_in = sat_add32(far_sum_ff, {16'b0, req_data.cell_population});
                        if (far_cnt_ff < FAR_CNT_MAX) begin
                           far_cnt_in = far_cnt_ff + 1'b1;
                        end
                        rsp_in.far_flag = 1'b1;
                     end else begin
                        rsp_valid_in = 1'b0;
                        iss_in   = '0;
                        far_in   = 1'b1;
                        best_in  = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_FINISH: begin
                     if (count_ff == '0) begin
                        rsp_in.total_people = total_ff;
                        rsp_in.far_people   = far_sum_ff;
                        rsp_in.far_cells    = far_cnt_ff;
                     end else begin
                        rsp_valid_in = 1'b0;
                        fk_in    = '0;
                        state_in = ST_FIN_RD;
                     end
                  end
                  default: begin
                     count_in   = '0;
                     total_in   = '0;
                     far_sum_in = '0;
                     far_cnt_in = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // issue one site read per cycle
            if (iss_ff < count_ff) begin
               v1_in  = 1'b1;
               iss_in = iss_ff + 1'b1;
            end
            // compare the finished distance against the running best
            if (v2_ff) begin
               if (k2_ff == '0 || dist_sum < best_d_ff) begin
                  best_d_in = dist_sum;
                  best_in   = k2_ff;
               end
               if (dist_sum <= FAR_LIMIT) begin
                  far_in = 1'b0;
               end
            end
            if (iss_ff == count_ff && !v1_ff && !v2_ff) begin
               state_in = ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            state_in = ST_POP_WR;
         end
         ST_POP_WR: begin
            pop_we   = 1'b1;
            pop_wa   = best_ff;
            pop_wd   = new_pop;
            total_in = sat_add32(total_ff, {16'b0, cpop_ff});
            if (far_ff) begin
               far_sum_in = sat_add32(far_sum_ff, {16'b0, cpop_ff});
               if (far_cnt_ff < FAR_CNT_MAX) begin
                  far_cnt_in = far_cnt_ff + 1'b1;
               end
            end
            rsp_valid_in        = 1'b1;
            rsp_in.kind         = OP_CELL;
            rsp_in.nearest_site = 6'(best_ff);
            rsp_in.site_found   = 1'b1;
            rsp_in.far_flag     = far_ff;
            state_in            = ST_IDLE;
         end
         ST_FIN_RD: begin
            state_in = ST_FIN_MUL;
         end
         ST_FIN_MUL: begin
            state_in = ST_FIN_CMP;
         end
         ST_FIN_CMP: begin
            // strict greater ratio, first site seeds the search
            if (fk_ff == '0 || lhs_ff > rhs_ff) begin
               best_in = fk_ff[SITE_W-1:0];
               bpop_in = cand_pop_ff;
               bcap_in = cand_cap_ff;
            end
            if (fk_ff + 1'b1 < count_ff) begin
               fk_in    = fk_ff + 1'b1;
               state_in = ST_FIN_RD;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               rsp_valid_in        = 1'b1;
               rsp_in.kind         = OP_FINISH;
               rsp_in.nearest_site = 6'(best_ff);
               rsp_in.site_found   = 1'b1;
               rsp_in.days_needed  = div_res.quotient + 32'(div_res.rem_nz);
               rsp_in.total_people = total_ff;
               rsp_in.far_people   = far_sum_ff;
               rsp_in.far_cells    = far_cnt_ff;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         far_sum_ff   <= '0;
         far_cnt_ff   <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         far_sum_ff   <= far_sum_in;
         far_cnt_ff   <= far_cnt_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff       <= px_in;
      py_ff       <= py_in;
      cpop_ff     <= cpop_in;
      iss_ff      <= iss_in;
      k1_ff       <= k1_in;
      k2_ff       <= k2_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      best_ff     <= best_in;
      best_d_ff   <= best_d_in;
      far_ff      <= far_in;
      fk_ff       <= fk_in;
      lhs_ff      <= lhs_in;
      rhs_ff      <= rhs_in;
      cand_pop_ff <= cand_pop_in;
      cand_cap_ff <= cand_cap_in;
      bpop_ff     <= bpop_in;
      bcap_ff     <= bcap_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a response only appears once the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");

   // site table never overfills
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SITES)) else $error("site count overflow");

   // far cell count stays within its cap
   a_far_max: assert property (@(posedge clock) disable iff (reset)
      far_cnt_ff <= FAR_CNT_MAX) else $error("far count overflow");

   // a load answers in the next cycle
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.opcode == OP_LOAD) |=> rsp_valid)
      else $error("load without response");
endmodule
`default_nettype wire

@@ hdl/nsc_ram.sv @@
// ---------------------------------------------------------------------------
// nsc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module nsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ hdl/nsc_div.sv @@
// ---------------------------------------------------------------------------
// nsc_div
// Restoring divider, one quotient bit per cycle for a 32-bit quotient.
// ---------------------------------------------------------------------------
`default_nettype none
module nsc_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [31:0]          dividend,
   input  wire logic [13:0]          divisor,
   output nsc_pkg::div_res_type      res
);
   import nsc_pkg::*;

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [13:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [13:0] dsr_ff, dsr_in;
   logic [14:0] trial;

   // one shift-subtract step per cycle
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[31]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = 5'd31;
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 14'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[13:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign res.done     = done_ff;
   assign res.quotient = quo_ff;
   assign res.rem_nz   = (rem_ff != '0);
endmodule
`default_nettype wire

@@ tb/sv/nearest_site_catchment_checker.sv @@
// ---------------------------------------------------------------------------
// nearest_site_catchment_checker
// Watches the request and response channels, predicts every response of the
// catchment block from its own copy of the site table and the sums, and
// compares each whole response against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module nearest_site_catchment_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             busy,
   input  wire nsc_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire nsc_pkg::rsp_type rsp_data,
   output int                    fail_count,
   output int                    pending_count
);
   import nsc_pkg::*;

   // predicted block state
   logic signed [15:0] site_x_tbl [MAX_SITES];
   logic signed [15:0] site_y_tbl [MAX_SITES];
   logic [13:0]        site_cap_tbl [MAX_SITES];
   logic [31:0]        site_pop_tbl [MAX_SITES];
   int                 sites_loaded;
   logic [31:0]        people_sum;
   logic [31:0]        far_people_sum;
   logic [14:0]        far_cell_sum;

   rsp_type expected_rsps [$];

   function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hffff_ffff : s[31:0];
   endfunction

   function automatic logic [63:0] square_dist(logic signed [63:0] d);
      logic [63:0] u;
      u = (d < 0) ? -d : d;
      return u * u;
   endfunction

   // compute response of one request and advance predicted state
   function automatic rsp_type catchment_response(req_type rq);
      rsp_type            r;
      logic signed [63:0] px, py;
      logic [63:0]        d, best_d, lhs, rhs, cap;
      int                 best;
      logic               far;
      r = '0;
      r.kind = rq.opcode;
      case (op_type'(rq.opcode))
         OP_LOAD: begin
            if (sites_loaded >= MAX_SITES) begin
               r.table_full = 1'b1;
            end else begin
               site_x_tbl[sites_loaded]   = rq.site_x;
               site_y_tbl[sites_loaded]   = rq.site_y;
               site_cap_tbl[sites_loaded] = (rq.site_capacity == 0) ? 14'd1 : rq.site_capacity;
               site_pop_tbl[sites_loaded] = '0;
               r.nearest_site = sites_loaded[5:0];
               sites_loaded++;
            end
            r.site_found = (sites_loaded > 0);
         end
         OP_CELL: begin
            px = 64'(rq.cell_row) <<< 8;
            py = 64'(rq.cell_col) <<< 8;
            best_d = '0;
            best = 0;
            far = 1'b1;
            for (int k = 0; k < sites_loaded; k++) begin
               d = square_dist(px - 64'(site_x_tbl[k])) + square_dist(py - 64'(site_y_tbl[k]));
               if (k == 0 || d < best_d) begin
                  best_d = d;
                  best = k;
               end
               if (d <= 64'(FAR_LIMIT)) far = 1'b0;
            end
            people_sum = add_clamped(people_sum, 32'(rq.cell_population));
            if (sites_loaded > 0) begin
               site_pop_tbl[best] = add_clamped(site_pop_tbl[best], 32'(rq.cell_population));
               r.nearest_site = best[5:0];
               r.site_found = 1'b1;
            end
            if (far) begin
               far_people_sum = add_clamped(far_people_sum, 32'(rq.cell_population));
               if (far_cell_sum < FAR_CNT_MAX) far_cell_sum++;
               r.far_flag = 1'b1;
            end
         end
         OP_FINISH: begin
            if (sites_loaded > 0) begin
               best = 0;
               for (int k = 1; k < sites_loaded; k++) begin
                  lhs = 64'(site_pop_tbl[k]) * 64'(site_cap_tbl[best]);
                  rhs = 64'(site_pop_tbl[best]) * 64'(site_cap_tbl[k]);
                  if (lhs > rhs) best = k;
               end
               cap = 64'(site_cap_tbl[best]);
               r.nearest_site = best[5:0];
               r.site_found = 1'b1;
               r.days_needed = 32'((64'(site_pop_tbl[best]) + cap - 1) / cap);
            end
            r.total_people = people_sum;
            r.far_people = far_people_sum;
            r.far_cells = far_cell_sum;
         end
         default: begin
            sites_loaded = 0;
            people_sum = '0;
            far_people_sum = '0;
            far_cell_sum = '0;
         end
      endcase
      return r;
   endfunction

   // predict on each request transfer, compare on each response strobe
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         sites_loaded   = 0;
         people_sum     = '0;
         far_people_sum = '0;
         far_cell_sum   = '0;
         expected_rsps.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want !== rsp_data) begin
                  $display("%0t: response mismatch expected %p actual %p",
                           $time, want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) expected_rsps.push_back(catchment_response(req_data));
         pending_count <= expected_rsps.size();
      end
   end

endmodule
`default_nettype wire

@@ tb/sv/nearest_site_catchment_tb.sv @@
// ---------------------------------------------------------------------------
// nearest_site_catchment_tb
// Drives directed and random site loads, grid cells, finishes and clears
// into the catchment block in bursts; the checker predicts and compares.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module nearest_site_catchment_tb;
   import nsc_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   int      cycle_count;
   int      burst_left;

   nearest_site_catchment dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   nearest_site_catchment_checker checker_inst (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("nearest_site_catchment_tb: done, errors");
         $finish;
      end
   end

   // one request transfer, with gaps between random-length bursts
   task automatic send_request(req_type rq);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
   endtask

   function automatic req_type noise_fields();
      req_type     rq;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      rq = raw[$bits(req_type)-1:0];
      return rq;
   endfunction

   task automatic load_site(logic signed [15:0] x, logic signed [15:0] y, logic [13:0] cap);
      req_type rq;
      rq = noise_fields();
      rq.opcode = OP_LOAD;
      rq.site_x = x;
      rq.site_y = y;
      rq.site_capacity = cap;
      send_request(rq);
   endtask

   task automatic send_cell(logic [6:0] r, logic [6:0] c, logic [15:0] pop);
      req_type rq;
      rq = noise_fields();
      rq.opcode = OP_CELL;
      rq.cell_row = r;
      rq.cell_col = c;
      rq.cell_population = pop;
      send_request(rq);
   endtask

   task automatic send_op(op_type op);
      req_type rq;
      rq = noise_fields();
      rq.opcode = op;
      send_request(rq);
   endtask

   // site near the grid most of the time, anywhere now and then
   function automatic logic signed [15:0] site_coord();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 127 * 256));
   endfunction

   initial begin
      int n_sites, n_cells;
      int r0, c0;
      cycle_count = 0;
      burst_left  = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, tie, zero capacity, overflow, clear
      send_cell(7'd0, 7'd0, 16'hffff);
      send_op(OP_FINISH);
      load_site(16'sh7fff, 16'sh8000, 14'd9999);
      load_site(16'sh0500, 16'sh0500, 14'd0);
      load_site(16'sh0700, 16'sh0500, 14'd1);
      load_site(16'sh8000, 16'sh7fff, 14'h3fff);
      send_cell(7'd6, 7'd5, 16'hffff);
      send_cell(7'd10, 7'd5, 16'd0);
      send_cell(7'd127, 7'd127, 16'hffff);
      send_cell(7'd5, 7'd10, 16'd1234);
      send_cell(7'd5, 7'd11, 16'd4321);
      send_op(OP_FINISH);
      for (int k = 4; k < MAX_SITES + 2; k++) load_site(site_coord(), site_coord(), 14'd1);
      send_cell(7'd64, 7'd64, 16'd777);
      send_op(OP_FINISH);
      send_op(OP_CLEAR);
      send_op(OP_FINISH);
      // large populations on one small-capacity site
      load_site(16'sh0000, 16'sh0000, 14'd1);
      repeat (20) send_cell(7'd127, 7'd0, 16'hffff);
      send_op(OP_FINISH);
      send_op(OP_CLEAR);

      // random sessions: load sites, stream cells in a small random patch, finish, often clear
      for (int done_items = 0; done_items < 1750;) begin
         n_sites = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 8);
         for (int k = 0; k < n_sites; k++)
            load_site(site_coord(), site_coord(), 14'($urandom_range(0, 16383)));
         n_cells = $urandom_range(5, 40);
         r0 = $urandom_range(0, 127);
         c0 = $urandom_range(0, 127);
         for (int k = 0; k < n_cells; k++) begin
            if ($urandom_range(0, 9) == 0) send_op(op_type'($urandom_range(0, 2)));
            send_cell(7'(r0 + $urandom_range(0, 8)), 7'(c0 + $urandom_range(0, 8)),
                      ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom));
         end
         send_op(OP_FINISH);
         if ($urandom_range(0, 2) != 0) send_op(OP_CLEAR);
         done_items += n_sites + n_cells + 2;
      end
      start <= 1'b0;

      // drain
      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("nearest_site_catchment_tb: done, clean");
      else
         $display("nearest_site_catchment_tb: done, errors");
      $finish;
   end

endmodule
`default_nettype wire

@@ nearest_site_catchment.f @@
hdl/nsc_pkg.sv
hdl/nsc_ram.sv
hdl/nsc_div.sv
hdl/nearest_site_catchment.sv
tb/sv/nearest_site_catchment_checker.sv
tb/sv/nearest_site_catchment_tb.sv
